// ----- rtl/core/text_console_cell_writer_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the text console cell writer
// Shared shorthand for clocked checks with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CELL_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_CELL_WRITER_TOP_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define TCW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants of the text console cell writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int DEFAULT_MAX_COLUMNS = 128;
   localparam int DEFAULT_MAX_ROWS    = 32;
   localparam int CSR_DATA_W          = 8;
   localparam int TAB_STOP            = 8;

   localparam logic [7:0] COLUMNS_RESET = 8'd80;
   localparam logic [5:0] ROWS_RESET    = 6'd25;

   localparam logic [7:0] CHAR_BS  = 8'h08;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_CR  = 8'h0D;

   localparam logic [7:0] COL_LIMIT     = 8'hFF;
   localparam logic [8:0] LINE_LIMIT    = 9'd511;
   localparam logic [4:0] ROW_OUT_LIMIT = 5'd31;

   typedef enum logic [1:0] {
      KIND_PUT   = 2'd0,
      KIND_CLEAR = 2'd1,
      KIND_READ  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [0:0] {
      CSR_COLUMNS = 1'b0,
      CSR_ROWS    = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_PUT_SETUP,
      ST_PUT,
      ST_SCROLL_CHK,
      ST_SCROLL_OFF,
      ST_SCROLL_TOTAL,
      ST_COPY,
      ST_ZERO,
      ST_READ_ADDR,
      ST_READ_DATA
   } state_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] char_code;
      logic [7:0] repeat_count;
      logic [4:0] read_row;
      logic [6:0] read_col;
   } req_type;

   typedef struct packed {
      logic [7:0] cursor_col;
      logic [4:0] cursor_row;
      logic [7:0] cell_value;
   } rsp_type;

endpackage

// ----- rtl/core/text_console_cell_writer_top.sv -----
// ----------------------------------------------------------------------------
// text_console_cell_writer_top
// Character-cell text console: put runs, clear, cell read, scroll-up.
// ----------------------------------------------------------------------------
// Each request yields exactly one response, shown on rsp_data for a single
// cycle while rsp_valid is high; the receiver cannot stall, so capture it
// then. A request is taken when start is high and busy is low. A put first
// forms the row base of the cursor line, then handles its bytes in turn and,
// when the cursor ends below the last row, runs the row walk (one cell per
// cycle through the single write port: copy the kept rows, zero the freed
// ones). A clear writes every store entry, one per cycle. A read multiplies
// for the address, then does the registered memory read. The unused kind
// is answered in the cycle after it is taken and leaves busy low. After
// reset the block sweeps the whole store to zero, holding busy high and
// giving no response; configuration writes are taken at any time but must
// only be issued while the block is idle.
// ----------------------------------------------------------------------------
`include "text_console_cell_writer_top_assert.svh"

module text_console_cell_writer_top #(
   parameter int MAX_COLUMNS = tcw_pkg::DEFAULT_MAX_COLUMNS,
   parameter int MAX_ROWS    = tcw_pkg::DEFAULT_MAX_ROWS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  tcw_pkg::req_type                req_data,
   output logic                            rsp_valid,
   output tcw_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  tcw_pkg::csr_index_type          csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tcw_pkg::*;

   // Store geometry: cells are packed row after row with a pitch of the
   // columns in use, so the linear address is row * w + col.
   localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int COL_W  = $clog2(MAX_COLUMNS + 1);
   localparam int ROW_W  = $clog2(MAX_ROWS + 1);
   localparam int PROD_W = ROW_W + COL_W;

   localparam logic [CNT_W-1:0] LAST_CELL = CNT_W'(DEPTH - 1);
   localparam logic [8:0]       MAX_COLS9 = 9'(MAX_COLUMNS);
   localparam logic [7:0]       MAX_ROWS8 = 8'(MAX_ROWS);

   // Control state
   state_type         state_ff, state_in;
   logic [7:0]        col_ff, col_in;
   logic [8:0]        line_ff, line_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              pend_ff, pend_in;
   logic              clr_rsp_ff, clr_rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        columns_ff;
   logic [5:0]        rows_ff;

   // Payload registers
   req_type           req_ff, req_in;
   logic [CNT_W-1:0]  base_ff, base_in;
   logic [7:0]        count_ff, count_in;
   logic [ROW_W-1:0]  amount_ff, amount_in;
   logic [CNT_W-1:0]  off_ff, off_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic              rd_hit_ff, rd_hit_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // Cell store
   logic [7:0]        mem [DEPTH];
   logic [7:0]        rd_data_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [ADDR_W-1:0] mem_raddr;
   logic [7:0]        mem_wdata;

   // Effective screen size
   logic [8:0]        cols9;
   logic [8:0]        w9;
   logic [7:0]        rows8;
   logic [7:0]        h8;
   logic [8:0]        h9;
   logic [COL_W-1:0]  w;
   logic [ROW_W-1:0]  h;

   // Shared multiplier
   logic [ROW_W-1:0]  mul_a;
   logic [PROD_W-1:0] mul_p;
   logic [CNT_W-1:0]  mul_cnt;

   // Status terms
   logic              req_fire;
   logic              line_on;
   logic              col_on;
   logic              put_done;
   logic [CNT_W-1:0]  src_cnt;
   logic              copy_more;
   logic              zero_more;
   logic              clear_last;
   logic [7:0]        cell_val;

   // ------------------------------------------------------------------------
   // Clamp the column and row registers to the built size; zero counts as one.
   // ------------------------------------------------------------------------
   assign cols9 = {1'b0, columns_ff};
   assign w9    = (cols9 > MAX_COLS9) ? MAX_COLS9 : ((cols9 == 9'd0) ? 9'd1 : cols9);
   assign rows8 = {2'b00, rows_ff};
   assign h8    = (rows8 > MAX_ROWS8) ? MAX_ROWS8 : ((rows8 == 8'd0) ? 8'd1 : rows8);
   assign h9    = {1'b0, h8};
   assign w     = COL_W'(w9);
   assign h     = ROW_W'(h8);

   // One multiplier, operand picked by state: row base, scroll offset,
   // screen size and read address all need some row count times w.
   assign mul_p   = PROD_W'(mul_a) * PROD_W'(w);
   assign mul_cnt = mul_p[CNT_W-1:0];

   assign req_fire   = start && !busy;
   assign line_on    = line_ff < h9;
   assign col_on     = {1'b0, col_ff} < w9;
   assign put_done   = count_ff == 8'd0;
   assign src_cnt    = idx_ff + off_ff;
   assign copy_more  = src_cnt < total_ff;
   assign zero_more  = idx_ff < total_ff;
   assign clear_last = idx_ff == LAST_CELL;

   assign busy      = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_data.kind)
                  KIND_PUT:   state_in = ST_PUT_SETUP;
                  KIND_CLEAR: state_in = ST_CLEAR;
                  KIND_READ:  state_in = ST_READ_ADDR;
                  KIND_NONE:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLEAR: begin
            if (clear_last) state_in = ST_IDLE;
         end
         ST_PUT_SETUP:    state_in = ST_PUT;
         ST_PUT: begin
            if (put_done) state_in = ST_SCROLL_CHK;
         end
         ST_SCROLL_CHK:   state_in = line_on ? ST_IDLE : ST_SCROLL_OFF;
         ST_SCROLL_OFF:   state_in = ST_SCROLL_TOTAL;
         ST_SCROLL_TOTAL: state_in = ST_COPY;
         ST_COPY: begin
            // wait for the last write-back before the zero fill takes the port
            if (!copy_more && !pend_ff) state_in = ST_ZERO;
         end
         ST_ZERO: begin
            if (!zero_more) state_in = ST_IDLE;
         end
         ST_READ_ADDR:    state_in = ST_READ_DATA;
         ST_READ_DATA:    state_in = ST_IDLE;
         default:         state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------------
   // Datapath, memory ports and response
   // ------------------------------------------------------------------------
   always_comb begin
      logic [8:0] col_inc;
      logic [8:0] tab_pos;
      logic [8:0] diff9;
      logic [8:0] amt9;
      logic       step_line;

      col_inc   = {1'b0, col_ff} + 9'd1;
      tab_pos   = ({1'b0, col_ff} + 9'(TAB_STOP)) & ~9'(TAB_STOP - 1);
      diff9     = line_ff - h9 + 9'd1;
      amt9      = (diff9 > h9) ? h9 : diff9;
      step_line = 1'b0;

      col_in       = col_ff;
      line_in      = line_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      clr_rsp_in   = clr_rsp_ff;
      rsp_valid_in = 1'b0;
      req_in       = req_ff;
      base_in      = base_ff;
      count_in     = count_ff;
      amount_in    = amount_ff;
      off_in       = off_ff;
      total_in     = total_ff;
      pend_addr_in = pend_addr_ff;
      rd_hit_in    = rd_hit_ff;
      cell_val     = 8'd0;
      mul_a        = '0;
      mem_we       = 1'b0;
      mem_waddr    = pend_addr_ff;
      mem_wdata    = 8'd0;
      mem_raddr    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               // latch the request; home the cursor now for a clear
               req_in   = req_data;
               count_in = req_data.repeat_count;
               if (req_data.kind == KIND_CLEAR) begin
                  col_in     = 8'd0;
                  line_in    = 9'd0;
                  idx_in     = '0;
                  clr_rsp_in = 1'b1;
               end
               rsp_valid_in = req_data.kind == KIND_NONE;
            end
         end

         ST_CLEAR: begin
            // sweep every entry, not just the visible screen
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(idx_ff);
            idx_in    = idx_ff + CNT_W'(1);
            if (clear_last) begin
               idx_in       = '0;
               rsp_valid_in = clr_rsp_ff;
               clr_rsp_in   = 1'b0;
            end
         end

         ST_PUT_SETUP: begin
            // row base of the cursor line; meaningless once the line is off screen
            mul_a   = ROW_W'(line_ff);
            base_in = mul_cnt;
         end

         ST_PUT: begin
            if (!put_done) begin
               count_in = count_ff - 8'd1;
               priority if (req_ff.char_code == CHAR_BS && col_ff != 8'd0) begin
                  col_in = col_ff - 8'd1;
               end else if (req_ff.char_code == CHAR_TAB) begin
                  col_in = (tab_pos > 9'(COL_LIMIT)) ? COL_LIMIT : tab_pos[7:0];
               end else if (req_ff.char_code == CHAR_CR) begin
                  col_in = 8'd0;
               end else if (req_ff.char_code == CHAR_LF) begin
                  col_in    = 8'd0;
                  step_line = 1'b1;
               end else begin
                  // ordinary byte: store if on screen, then advance and wrap
                  if (col_on && line_on) begin
                     mem_we    = 1'b1;
                     mem_waddr = ADDR_W'(base_ff + CNT_W'(col_ff));
                     mem_wdata = req_ff.char_code;
                  end
                  if (col_inc >= w9) begin
                     col_in    = 8'd0;
                     step_line = 1'b1;
                  end else begin
                     col_in = col_inc[7:0];
                  end
               end
               if (step_line) begin
                  // keep the row base only while it still points on screen
                  if (line_on) base_in = base_ff + CNT_W'(w);
                  if (line_ff < LINE_LIMIT) line_in = line_ff + 9'd1;
               end
            end
         end

         ST_SCROLL_CHK: begin
            if (line_on) begin
               rsp_valid_in = 1'b1;
            end else begin
               amount_in = ROW_W'(amt9);
            end
         end

         ST_SCROLL_OFF: begin
            mul_a  = amount_ff;
            off_in = mul_cnt;
         end

         ST_SCROLL_TOTAL: begin
            mul_a    = h;
            total_in = mul_cnt;
            idx_in   = '0;
         end

         ST_COPY: begin
            // write back the cell read last cycle; sources always lie ahead
            // of the destinations, so the stream needs no forwarding
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pend_addr_ff;
               mem_wdata = rd_data_ff;
            end
            if (copy_more) begin
               mem_raddr    = ADDR_W'(src_cnt);
               pend_in      = 1'b1;
               pend_addr_in = ADDR_W'(idx_ff);
               idx_in       = idx_ff + CNT_W'(1);
            end
         end

         ST_ZERO: begin
            // idx starts where the copy stopped: the first freed row
            if (zero_more) begin
               mem_we    = 1'b1;
               mem_waddr = ADDR_W'(idx_ff);
               idx_in    = idx_ff + CNT_W'(1);
            end else begin
               line_in      = h9 - 9'd1;
               rsp_valid_in = 1'b1;
            end
         end

         ST_READ_ADDR: begin
            mul_a     = ROW_W'(req_ff.read_row);
            mem_raddr = ADDR_W'(mul_cnt + CNT_W'(req_ff.read_col));
            rd_hit_in = ({3'b000, req_ff.read_row} < h8) &&
                        ({2'b00, req_ff.read_col} < w9);
         end

         ST_READ_DATA: begin
            rsp_valid_in = 1'b1;
            cell_val     = rd_hit_ff ? rd_data_ff : 8'd0;
         end

         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase

      rsp_data_in.cursor_col = col_in;
      rsp_data_in.cursor_row = (line_in > 9'(ROW_OUT_LIMIT)) ? ROW_OUT_LIMIT : line_in[4:0];
      rsp_data_in.cell_value = cell_val;
   end

   // ------------------------------------------------------------------------
   // Control registers; reset starts the clearing sweep
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         col_ff       <= 8'd0;
         line_ff      <= 9'd0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         columns_ff   <= COLUMNS_RESET;
         rows_ff      <= ROWS_RESET;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         line_ff      <= line_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_COLUMNS: columns_ff <= csr_wdata;
               CSR_ROWS:    rows_ff    <= csr_wdata[5:0];
            endcase
         end
      end
   end

   // Payload registers: hold without reset
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      base_ff      <= base_in;
      count_ff     <= count_in;
      amount_ff    <= amount_in;
      off_ff       <= off_in;
      total_ff     <= total_in;
      pend_addr_ff <= pend_addr_in;
      rd_hit_ff    <= rd_hit_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Cell store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= mem[mem_raddr];
   end

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `TCW_ASSERT_NEXT(a_put_holds_busy, clock, reset, req_fire && (req_data.kind == KIND_PUT), busy, "put request did not start a run")
   `TCW_ASSERT_NOW(a_copy_wb_in_walk, clock, reset, pend_ff, state_ff == ST_COPY, "copy write-back outside the row walk")
   `TCW_ASSERT_NOW(a_scroll_lands_last_row, clock, reset, rsp_valid_ff && ($past(state_ff) == ST_ZERO), line_ff == (h9 - 9'd1), "scroll did not leave the cursor on the last row")

endmodule

// ----- tb/sv/text_console_cell_writer_top_tb.sv -----
// ----------------------------------------------------------------------------
// text_console_cell_writer_top_tb
// Self-checking bench for the character-cell text console. Put runs, clears,
// cell reads and unused requests go through the start/busy port, and the
// screen geometry is changed between phases over the CSR channel. A screen
// model in the bench predicts every response, including cursor moves, edge
// clipping and scroll-up.
// ----------------------------------------------------------------------------
module text_console_cell_writer_top_tb;
   import tcw_pkg::*;

   localparam int STORE_DEPTH   = DEFAULT_MAX_COLUMNS * DEFAULT_MAX_ROWS;
   localparam int MAX_REPORTS   = 10;
   localparam int CYCLE_LIMIT   = 30_000_000;
   localparam int NUM_PHASES    = 24;
   localparam int SETTLE_CYCLES = 8;
   localparam int END_CYCLES    = 64;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_data;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // -------------------------------------------------------------------------
   // Screen model: own copy of the cell store, cursor and geometry registers.
   // take_request() computes the response a request must produce and queues
   // it; match_response() pops the oldest one and compares field by field.
   // -------------------------------------------------------------------------
   class console_screen_model;
      byte unsigned cells [STORE_DEPTH];
      int           col;
      int           line;
      logic [7:0]   columns_reg;
      logic [5:0]   rows_reg;
      rsp_type      awaited [$];
      int           taken_count;
      int           checked_count;
      int           scroll_count;
      int           error_count;

      function void clear_all();
         foreach (cells[i]) cells[i] = 8'd0;
         col  = 0;
         line = 0;
      endfunction

      function void power_up();
         clear_all();
         columns_reg   = COLUMNS_RESET;
         rows_reg      = ROWS_RESET;
         taken_count   = 0;
         checked_count = 0;
         scroll_count  = 0;
         error_count   = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [7:0] value);
         if (idx == CSR_COLUMNS) columns_reg = value;
         else rows_reg = value[5:0];
      endfunction

      // Clamp the registers to the store; zero counts as one.
      function int visible_columns();
         int c;
         c = columns_reg;
         if (c > DEFAULT_MAX_COLUMNS) c = DEFAULT_MAX_COLUMNS;
         if (c == 0) c = 1;
         return c;
      endfunction

      function int visible_rows();
         int r;
         r = rows_reg;
         if (r > DEFAULT_MAX_ROWS) r = DEFAULT_MAX_ROWS;
         if (r == 0) r = 1;
         return r;
      endfunction

      function void step_down_line();
         if (line < LINE_LIMIT) line++;
      endfunction

      function void put_byte(logic [7:0] code, int w, int h);
         int x;
         if (code == CHAR_BS && col != 0) begin
            col--;
         end else if (code == CHAR_TAB) begin
            x   = (col + TAB_STOP) / TAB_STOP * TAB_STOP;
            col = (x > COL_LIMIT) ? COL_LIMIT : x;
         end else if (code == CHAR_CR) begin
            col = 0;
         end else if (code == CHAR_LF) begin
            col = 0;
            step_down_line();
         end else begin
            // clip writes outside the visible area, but move the cursor anyway
            if (col < w && line < h) cells[line * w + col] = code;
            col++;
            if (col >= w) begin
               col = 0;
               step_down_line();
            end
         end
      endfunction

      function void scroll_into_view(int w, int h);
         int amount;
         if (line < h) return;
         amount = line - h + 1;
         if (amount > h) amount = h;
         for (int i = 0; i + amount < h; i++)
            for (int j = 0; j < w; j++) cells[i * w + j] = cells[(i + amount) * w + j];
         for (int i = h - amount; i < h; i++)
            for (int j = 0; j < w; j++) cells[i * w + j] = 8'd0;
         line = h - 1;
         scroll_count++;
      endfunction

      function void take_request(req_type r);
         int      w;
         int      h;
         rsp_type expected;
         w        = visible_columns();
         h        = visible_rows();
         expected = '0;
         case (r.kind)
            KIND_PUT: begin
               for (int i = 0; i < r.repeat_count; i++) put_byte(r.char_code, w, h);
               scroll_into_view(w, h);
            end
            KIND_CLEAR: begin
               clear_all();
            end
            KIND_READ: begin
               if (r.read_row < h && r.read_col < w)
                  expected.cell_value = cells[r.read_row * w + r.read_col];
            end
            default: begin
            end
         endcase
         expected.cursor_col = (col > COL_LIMIT) ? COL_LIMIT : col[7:0];
         expected.cursor_row = (line > ROW_OUT_LIMIT) ? ROW_OUT_LIMIT : line[4:0];
         awaited.push_back(expected);
         taken_count++;
      endfunction

      function void match_response(rsp_type got);
         rsp_type expected;
         if (awaited.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("ERROR: unexpected response col=%0d row=%0d cell=%02h",
                        got.cursor_col, got.cursor_row, got.cell_value);
            return;
         end
         expected = awaited.pop_front();
         checked_count++;
         if (got.cursor_col !== expected.cursor_col ||
             got.cursor_row !== expected.cursor_row ||
             got.cell_value !== expected.cell_value) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("ERROR: response %0d expected col=%0d row=%0d cell=%02h, got col=%0d row=%0d cell=%02h",
                        checked_count, expected.cursor_col, expected.cursor_row,
                        expected.cell_value, got.cursor_col, got.cursor_row, got.cell_value);
         end
      endfunction
   endclass

   console_screen_model screen;
   int                  cycle_count = 0;
   int                  idle_pct    = 0;

   // Geometry per phase: mostly small screens so scrolls and clears stay cheap,
   // plus the register extremes (zero, out of range, the full store).
   logic [7:0] phase_columns [NUM_PHASES] = '{8'd8, 8'd1, 8'd0, 8'd16, 8'd128, 8'd255,
      8'd5, 8'd12, 8'd3, 8'd9, 8'd2, 8'd80, 8'd10, 8'd7, 8'd32, 8'd16, 8'd4, 8'd128,
      8'd6, 8'd200, 8'd24, 8'd64, 8'd11, 8'd8};
   logic [7:0] phase_rows [NUM_PHASES] = '{8'd4, 8'd2, 8'd0, 8'd6, 8'd1, 8'd63,
      8'd3, 8'd8, 8'd32, 8'd5, 8'd1, 8'd25, 8'd10, 8'd2, 8'd4, 8'd16, 8'd4, 8'd2,
      8'd40, 8'd1, 8'd9, 8'd33, 8'd3, 8'hC5};

   text_console_cell_writer_top uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Observe every handshake on the pre-edge values: register writes update
   // the model geometry, accepted requests queue a prediction, strobed
   // responses are checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) screen.write_register(csr_index, csr_wdata);
         if (start && !busy) screen.take_request(req_data);
         if (rsp_valid) screen.match_response(rsp_data);
      end
   end

   // Hold start high until the block takes the request; insert idle cycles
   // beforehand at the current idle rate. Leave start high on return so that
   // back-to-back requests need no extra edge.
   task automatic issue_request(req_type r);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_data <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // Drop start, wait for every outstanding response and an idle block, then
   // hold a few more cycles.
   task automatic drain(int extra);
      start <= 1'b0;
      do @(posedge clock); while (screen.awaited.size() != 0 || busy !== 1'b0);
      repeat (extra) @(posedge clock);
   endtask

   // Write columns then rows; keep valid high across both writes.
   task automatic program_screen(logic [7:0] cols, logic [7:0] rows);
      csr_valid <= 1'b1;
      csr_index <= CSR_COLUMNS;
      csr_wdata <= cols;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_index <= CSR_ROWS;
      csr_wdata <= rows;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type make_request(kind_type k, logic [7:0] code,
                                            logic [7:0] count, logic [4:0] row,
                                            logic [6:0] rcol);
      req_type r;
      r.kind         = k;
      r.char_code    = code;
      r.repeat_count = count;
      r.read_row     = row;
      r.read_col     = rcol;
      return r;
   endfunction

   // Mostly put runs and reads inside the visible area, with control bytes
   // mixed in so the cursor walks, wraps and scrolls; a few clears and
   // unused requests, and some reads and bytes over the full field range.
   function automatic req_type random_request(int w, int h);
      req_type r;
      int      pick;
      r.kind         = KIND_PUT;
      r.char_code    = 8'($urandom);
      r.repeat_count = 8'($urandom);
      r.read_row     = 5'($urandom);
      r.read_col     = 7'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
         r.kind = KIND_CLEAR;
      end else if (pick < 5) begin
         r.kind = KIND_NONE;
      end else if (pick < 40) begin
         r.kind = KIND_READ;
         if ($urandom_range(0, 9) < 8) begin
            r.read_row = 5'($urandom_range(0, h - 1));
            r.read_col = 7'($urandom_range(0, w - 1));
         end
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 6) r.char_code = CHAR_BS;
         else if (pick < 12) r.char_code = CHAR_TAB;
         else if (pick < 18) r.char_code = CHAR_CR;
         else if (pick < 26) r.char_code = CHAR_LF;
         else if (pick >= 36) r.char_code = 8'($urandom_range(8'h20, 8'h7E));
         pick = $urandom_range(0, 99);
         if (pick < 6) r.repeat_count = 8'd0;
         else if (pick < 78) r.repeat_count = 8'($urandom_range(1, 4));
         else if (pick < 95) r.repeat_count = 8'($urandom_range(5, 40));
      end
      return r;
   endfunction

   initial begin
      int w;
      int h;
      int count;
      screen = new;
      screen.power_up();
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_COLUMNS;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // wait out the store sweep that follows reset
      do @(posedge clock); while (busy !== 1'b0);

      // Directed requests on the reset geometry (80 x 25).
      idle_pct = 36;
      issue_request(make_request(KIND_READ, 8'h00, 8'd0, 5'd0, 7'd0));
      issue_request(make_request(KIND_PUT, 8'h41, 8'd3, 5'd0, 7'd0));
      issue_request(make_request(KIND_READ, 8'h00, 8'd0, 5'd0, 7'd1));
      issue_request(make_request(KIND_PUT, CHAR_BS, 8'd1, 5'd0, 7'd0));
      issue_request(make_request(KIND_PUT, CHAR_CR, 8'd1, 5'd0, 7'd0));
      // backspace at column zero lands in the cell as an ordinary byte
      issue_request(make_request(KIND_PUT, CHAR_BS, 8'd1, 5'd0, 7'd0));
      issue_request(make_request(KIND_READ, 8'h00, 8'd0, 5'd0, 7'd0));
      issue_request(make_request(KIND_PUT, CHAR_TAB, 8'd1, 5'd0, 7'd0));
      // tab run past the right edge saturates the column
      issue_request(make_request(KIND_PUT, CHAR_TAB, 8'd40, 5'd0, 7'd0));
      // byte beyond the edge is dropped, cursor still wraps
      issue_request(make_request(KIND_PUT, 8'h5A, 8'd1, 5'd0, 7'd0));
      // long line-feed run scrolls by more than one row
      issue_request(make_request(KIND_PUT, CHAR_LF, 8'd30, 5'd0, 7'd0));
      issue_request(make_request(KIND_PUT, 8'h71, 8'd0, 5'd0, 7'd0));
      issue_request(make_request(KIND_READ, 8'h00, 8'd0, 5'd31, 7'd127));
      issue_request(make_request(KIND_READ, 8'h00, 8'd0, 5'd0, 7'd100));
      issue_request(make_request(KIND_NONE, 8'hA5, 8'd77, 5'd19, 7'd42));
      issue_request(make_request(KIND_PUT, 8'hFF, 8'd255, 5'd31, 7'd127));
      issue_request(make_request(KIND_PUT, 8'h00, 8'd1, 5'd0, 7'd0));
      issue_request(make_request(KIND_READ, 8'h00, 8'd0, 5'd21, 7'd0));
      issue_request(make_request(KIND_READ, 8'h00, 8'd0, 5'd24, 7'd14));
      issue_request(make_request(KIND_CLEAR, 8'h00, 8'd0, 5'd0, 7'd0));
      issue_request(make_request(KIND_READ, 8'h00, 8'd0, 5'd21, 7'd0));

      // Random phases: sender idles 36% of cycles, then 83%, then never.
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain(SETTLE_CYCLES);
         program_screen(phase_columns[p], phase_rows[p]);
         w        = screen.visible_columns();
         h        = screen.visible_rows();
         idle_pct = (p < 8) ? 36 : (p < 16) ? 83 : 0;
         // keep the large screens short; each scroll there walks the store
         count = (w * h <= 256) ? 85 : 15;
         repeat (count) issue_request(random_request(w, h));
      end

      drain(END_CYCLES);

      $display("Ran %0d requests over %0d screen geometries, %0d of them scrolled.",
               screen.taken_count, NUM_PHASES + 1, screen.scroll_count);
      $display("Checked %0d responses, %0d mismatches, %0d outstanding.",
               screen.checked_count, screen.error_count, screen.awaited.size());
      if (screen.error_count == 0 && screen.awaited.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Stop a hung run.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Cycle limit of %0d reached with %0d responses outstanding.",
               CYCLE_LIMIT, screen.awaited.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/tcw_pkg.sv
rtl/core/text_console_cell_writer_top.sv
tb/sv/text_console_cell_writer_top_tb.sv
